@@ sv/bts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

   // Node indices carry one bit more than the address so that "no child" fits.
   localparam int unsigned NODE_IDX_WIDTH = 7;
   localparam int unsigned STACK_WIDTH    = 6;
   localparam int unsigned VALUE_WIDTH    = 32;

   // Link code for "no child".
   localparam logic [NODE_IDX_WIDTH-1:0] NIL_LINK = 7'd64;

   // One entry of the node memory.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [NODE_IDX_WIDTH-1:0]     left;
      logic [NODE_IDX_WIDTH-1:0]     right;
   } node_type;

   // Command from the walk control to the walk stack.
   typedef struct packed {
      logic                   push;
      logic                   pop;
      logic [STACK_WIDTH-1:0] data;
   } stack_cmd_type;

endpackage

`default_nettype wire

@@ sv/binary_tree_sort_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                             | Transfer
// ---------+-----------------------------------+----------------------------------
// request  | start, busy, req_value, req_last  | edge with start high and busy low
// response | rsp_valid, rsp_value, rsp_last    | every edge that ends a rsp_valid cycle
//
// An insert writes the new node and then follows the path from the root down;
// the tree is descended one node per cycle through the single node-memory read port.
// A marked item then walks the tree in order, paced by the registered node-memory and
// stack reads, and results of the walk never come in consecutive cycles.
// Reset is synchronous and empties the tree; the memories are not cleared.
// The receiver cannot stall; busy is high during a descent and during the walk.

module binary_tree_sort_unit
   import bts_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   output logic signed [VALUE_WIDTH-1:0]      rsp_value,
   output logic                               rsp_last
);

   localparam int unsigned AddrWidth = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam logic [NODE_IDX_WIDTH-1:0] MaxCount = NODE_IDX_WIDTH'(MAX_ITEMS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DESCEND,
      ST_WALK_START,
      ST_PUSH_WAIT,
      ST_POP_WAIT,
      ST_EMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic [NODE_IDX_WIDTH-1:0]     count_ff, count_in;
   logic [NODE_IDX_WIDTH-1:0]     cur_ff, cur_in;
   logic [NODE_IDX_WIDTH-1:0]     fresh_ff, fresh_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          last_ff, last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;

   node_type                      node_mem [MAX_ITEMS];
   node_type                      rd_data_ff;
   logic                          node_re;
   logic [NODE_IDX_WIDTH-1:0]     node_rd_addr;
   logic                          node_we;
   logic [NODE_IDX_WIDTH-1:0]     node_wr_addr;
   node_type                      node_wr_data;

   stack_cmd_type                 stack_cmd;
   logic [STACK_WIDTH-1:0]        stack_data;
   logic                          stack_empty;

   logic                          go_right;
   logic [NODE_IDX_WIDTH-1:0]     child;
   logic                          child_valid;
   logic                          left_valid;
   logic                          right_valid;

   // Walk stack holding the node indices of pending ancestors.
   bts_walk_stack #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_walk_stack (
      .clock    (clock),
      .reset    (reset),
      .cmd      (stack_cmd),
      .pop_data (stack_data),
      .empty    (stack_empty)
   );

   // Branch decision on the node just read; links below the count are real children.
   assign go_right    = (value_ff > rd_data_ff.value);
   assign child       = go_right ? rd_data_ff.right : rd_data_ff.left;
   assign child_valid = (child < count_ff);
   assign left_valid  = (rd_data_ff.left < count_ff);
   assign right_valid = (rd_data_ff.right < count_ff);

   // Next-state logic for insertion and the in-order walk.
   always_comb begin
      node_type updated;

      updated       = rd_data_ff;
      state_in      = state_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      fresh_in      = fresh_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      node_re       = 1'b0;
      node_rd_addr  = cur_ff;
      node_we       = 1'b0;
      node_wr_addr  = count_ff;
      node_wr_data  = rd_data_ff;
      stack_cmd     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               last_in  = req_last;
               state_in = req_last ? ST_WALK_START : ST_IDLE;
               if (count_ff < MaxCount) begin
                  // Store the new node, then descend from the root if there is one.
                  node_we      = 1'b1;
                  node_wr_addr = count_ff;
                  node_wr_data = '{value: req_value, left: NIL_LINK, right: NIL_LINK};
                  fresh_in     = count_ff;
                  count_in     = count_ff + 7'd1;
                  if (count_ff != '0) begin
                     node_re      = 1'b1;
                     node_rd_addr = '0;
                     cur_in       = '0;
                     state_in     = ST_DESCEND;
                  end
               end
            end
         end

         ST_DESCEND: begin
            if (child_valid) begin
               node_re      = 1'b1;
               node_rd_addr = child;
               cur_in       = child;
            end else begin
               // Hang the new node on the free link and write the parent back.
               if (go_right) begin
                  updated.right = fresh_ff;
               end else begin
                  updated.left = fresh_ff;
               end
               node_we      = 1'b1;
               node_wr_addr = cur_ff;
               node_wr_data = updated;
               state_in     = last_ff ? ST_WALK_START : ST_IDLE;
            end
         end

         ST_WALK_START: begin
            stack_cmd    = '{push: 1'b1, pop: 1'b0, data: '0};
            node_re      = 1'b1;
            node_rd_addr = '0;
            state_in     = ST_PUSH_WAIT;
         end

         ST_PUSH_WAIT: begin
            if (left_valid) begin
               // Keep going down the left spine.
               stack_cmd    = '{push: 1'b1, pop: 1'b0,
                                data: rd_data_ff.left[STACK_WIDTH-1:0]};
               node_re      = 1'b1;
               node_rd_addr = rd_data_ff.left;
               state_in     = ST_PUSH_WAIT;
            end else begin
               stack_cmd = '{push: 1'b0, pop: 1'b1, data: '0};
               state_in  = ST_POP_WAIT;
            end
         end

         ST_POP_WAIT: begin
            node_re      = 1'b1;
            node_rd_addr = {1'b0, stack_data};
            state_in     = ST_EMIT;
         end

         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data_ff.value;
            rsp_last_in  = !right_valid && stack_empty;
            if (right_valid) begin
               stack_cmd    = '{push: 1'b1, pop: 1'b0,
                                data: rd_data_ff.right[STACK_WIDTH-1:0]};
               node_re      = 1'b1;
               node_rd_addr = rd_data_ff.right;
               state_in     = ST_PUSH_WAIT;
            end else if (stack_empty) begin
               // Walk done: empty the tree for the next set.
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               stack_cmd = '{push: 1'b0, pop: 1'b1, data: '0};
               state_in  = ST_POP_WAIT;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      fresh_ff     <= fresh_in;
      value_ff     <= value_in;
      last_ff      <= last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Node memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wr_addr[AddrWidth-1:0]] <= node_wr_data;
      end
      if (node_re) begin
         rd_data_ff <= node_mem[node_rd_addr[AddrWidth-1:0]];
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

@@ sv/bts_walk_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bts_walk_stack
   import bts_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire stack_cmd_type          cmd,
   output logic [STACK_WIDTH-1:0]      pop_data,
   output logic                        empty
);

   localparam int unsigned AddrWidth = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   logic [STACK_WIDTH-1:0]    stack_mem [MAX_ITEMS];
   logic [NODE_IDX_WIDTH-1:0] sp_ff;
   logic [NODE_IDX_WIDTH-1:0] sp_in;
   logic [NODE_IDX_WIDTH-1:0] sp_dec;
   logic [STACK_WIDTH-1:0]    pop_data_ff;

   assign sp_dec = sp_ff - 7'd1;

   // Stack pointer moves up on a push and down on a pop.
   always_comb begin
      sp_in = sp_ff;
      if (cmd.push) begin
         sp_in = sp_ff + 7'd1;
      end else if (cmd.pop) begin
         sp_in = sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // Stack memory: write on a push, registered read of the top entry on a pop.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[sp_ff[AddrWidth-1:0]] <= cmd.data;
      end
      if (cmd.pop) begin
         pop_data_ff <= stack_mem[sp_dec[AddrWidth-1:0]];
      end
   end

   assign pop_data = pop_data_ff;
   assign empty    = (sp_ff == '0);

endmodule

`default_nettype wire

@@ sv/bts_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bts_checker
   import bts_pkg::*;
(
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic signed [VALUE_WIDTH-1:0] rsp_value,
   input wire logic                          rsp_last
);

   // A result only comes out of a walk that was under way.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result transfer without a walk in progress");

   // Results of one walk never come in consecutive cycles.
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in two consecutive cycles");

   // The walk continues after every result that is not the last.
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("block went idle in the middle of a sorted run");

   // The block is already idle in the cycle that shows the final result.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy with the final result");

   // A strobed result carries known bits.
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_value, rsp_last}))
      else $error("result transfer with unknown bits");

endmodule

bind binary_tree_sort_unit bts_checker u_bts_checker (.*);

`default_nettype wire
